// File: rtl/mpss_pkg.sv
// ----------------------------------------------------------------------------
// mpss_pkg
// Shared widths, constants and types for the minimum-penalty stop sequencer.
// ----------------------------------------------------------------------------
package mpss_pkg;

  // field widths
  localparam int POS_W  = 16;
  localparam int COST_W = 40;

  // leg arithmetic widths: signed deviation, its magnitude and its square
  localparam int DEV_W = POS_W + 2;
  localparam int MAG_W = POS_W + 1;
  localparam int SQ_W  = 2 * MAG_W;

  // reset value of the target leg length
  localparam logic [POS_W-1:0] TARGET_RESET = 16'd200;

  // saturation ceiling for costs
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // one evaluated candidate leaving the leg evaluator
  typedef struct packed {
    logic              vld;
    logic              org;
    logic [POS_W-1:0]  pos;
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] sum;
  } leg_res_t;

endpackage

// File: rtl/mpss_leg_eval.sv
// ----------------------------------------------------------------------------
// mpss_leg_eval
// Three-stage candidate evaluator: deviation magnitude, square, then the
// saturating sum of predecessor cost and leg penalty.
// ----------------------------------------------------------------------------
module mpss_leg_eval
  import mpss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  logic              in_vld,
  input  logic              in_org,
  input  logic [POS_W-1:0]  in_pos,
  input  logic [COST_W-1:0] in_cost,
  input  logic [POS_W-1:0]  pref,
  input  logic [POS_W-1:0]  target,
  output leg_res_t          res,
  output logic              pipe_busy
);

  logic                     s2_vld_r;
  logic                     s2_org_r;
  logic [MAG_W-1:0]         s2_mag_r;
  logic [POS_W-1:0]         s2_pos_r;
  logic [COST_W-1:0]        s2_cost_r;
  logic                     s3_vld_r;
  logic                     s3_org_r;
  logic [SQ_W-1:0]          s3_sq_r;
  logic [POS_W-1:0]         s3_pos_r;
  logic [COST_W-1:0]        s3_cost_r;

  logic [POS_W-1:0]         pj;
  logic [COST_W-1:0]        cj;
  logic signed [DEV_W-1:0]  dev;
  logic [MAG_W-1:0]         mag;
  logic [COST_W:0]          sum_full;

  // origin candidate: milepost 0, cost 0
  assign pj = in_org ? '0 : in_pos;
  assign cj = in_org ? '0 : in_cost;

  // signed deviation target - (pref - pj), then magnitude
  assign dev = $signed({2'b00, target}) - ($signed({2'b00, pref}) - $signed({2'b00, pj}));
  assign mag = dev[DEV_W-1] ? MAG_W'(-dev) : MAG_W'(dev);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= in_vld & ~flush;
      s3_vld_r <= s2_vld_r & ~flush;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s2_org_r  <= in_org;
    s2_mag_r  <= mag;
    s2_pos_r  <= pj;
    s2_cost_r <= cj;
    s3_org_r  <= s2_org_r;
    s3_sq_r   <= s2_mag_r * s2_mag_r;
    s3_pos_r  <= s2_pos_r;
    s3_cost_r <= s2_cost_r;
  end

  // saturating cost sum
  assign sum_full = {1'b0, s3_cost_r} + (COST_W+1)'(s3_sq_r);

  assign res.vld  = s3_vld_r;
  assign res.org  = s3_org_r;
  assign res.pos  = s3_pos_r;
  assign res.cost = s3_cost_r;
  assign res.sum  = sum_full[COST_W] ? COST_MAX : sum_full[COST_W-1:0];

  assign pipe_busy = s2_vld_r | s3_vld_r;

endmodule

// File: rtl/min_penalty_stop_sequence.sv
// ----------------------------------------------------------------------------
// min_penalty_stop_sequence
// Loads stop mileposts, finds the stop sequence of minimum squared leg
// penalty from the origin to the last stop, and plays it out in order.
// ----------------------------------------------------------------------------
// Each word with start high while busy is low is one stop. The word with
// in_last high ends the list and busy rises. Costs are computed through one
// candidate evaluator fed from the position and cost memories, one candidate
// a cycle while the candidates of a stop are issued. The traceback then scans
// backward one candidate a cycle, restarting below each chosen stop. Each
// result is read from the stack and the position memory in turn and is shown
// on the out_ ports for one cycle with out_valid high; the receiver cannot
// stall and must take every word. Stops beyond MAX_STOPS are dropped and
// reported on out_overflow. cfg_wdata is taken as the target leg length
// whenever cfg_we is high.
// ----------------------------------------------------------------------------
module min_penalty_stop_sequence
  import mpss_pkg::*;
#(
  parameter int MAX_STOPS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [POS_W-1:0]  in_milepost,
  input  logic              in_last,
  output logic              out_valid,
  output logic [POS_W-1:0]  out_stop_milepost,
  output logic [COST_W-1:0] out_total_penalty,
  output logic              out_last_stop,
  output logic              out_overflow,
  input  logic              cfg_we,
  input  logic [POS_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CI   = 4'd1;
  localparam logic [3:0] S_CR   = 4'd2;
  localparam logic [3:0] S_CD   = 4'd3;
  localparam logic [3:0] S_TI   = 4'd4;
  localparam logic [3:0] S_TC   = 4'd5;
  localparam logic [3:0] S_TR   = 4'd6;
  localparam logic [3:0] S_TW   = 4'd7;
  localparam logic [3:0] S_EK   = 4'd8;
  localparam logic [3:0] S_EP   = 4'd9;
  localparam logic [3:0] S_EO   = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [AW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     depth_r, depth_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [POS_W-1:0]  pref_r, pref_nxt;
  logic [COST_W-1:0] ccur_r, ccur_nxt;
  logic [COST_W-1:0] best_r, best_nxt;
  logic [COST_W-1:0] total_r, total_nxt;
  logic [POS_W-1:0]  tgt_r, tgt_nxt;
  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_org_r, s1_org_nxt;
  logic [AW-1:0]     s1_j_r, s1_j_nxt;
  logic [AW-1:0]     s2_j_r;
  logic [AW-1:0]     s3_j_r;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_mp_r, out_mp_nxt;
  logic [COST_W-1:0] out_tot_r, out_tot_nxt;
  logic              out_lst_r, out_lst_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  // memory ports
  logic [POS_W-1:0]  pos_mem [MAX_STOPS];
  logic [COST_W-1:0] cost_mem [MAX_STOPS];
  logic [AW-1:0]     stk_mem [MAX_STOPS];
  logic              pos_we, cost_we, stk_we;
  logic [AW-1:0]     pos_waddr, pos_raddr, cost_raddr, stk_waddr, stk_raddr;
  logic [AW-1:0]     stk_wdata;
  logic [POS_W-1:0]  pos_q;
  logic [COST_W-1:0] cost_q;
  logic [AW-1:0]     stk_q;

  logic              accept;
  logic              full;
  logic [AW-1:0]     lastidx;
  logic              match;
  logic              ev_busy;
  leg_res_t          res;

  assign accept  = start & ~busy;
  assign full    = (cnt_r == CW'(MAX_STOPS));
  assign lastidx = AW'(n_r - CW'(1));
  assign busy    = (state_r != S_IDLE);

  // traceback hit: predecessor cost plus leg equals current cost
  assign match = res.vld && (res.sum == ccur_r) && ((state_r == S_TR) || (state_r == S_TW));

  // position memory
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= in_milepost;
    end
    pos_q <= pos_mem[pos_raddr];
  end

  // cost memory
  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[i_r] <= best_r;
    end
    cost_q <= cost_mem[cost_raddr];
  end

  // route stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  // candidate evaluator
  mpss_leg_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (match),
    .in_vld    (s1_vld_r),
    .in_org    (s1_org_r),
    .in_pos    (pos_q),
    .in_cost   (cost_q),
    .pref      (pref_r),
    .target    (tgt_r),
    .res       (res),
    .pipe_busy (ev_busy)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    depth_nxt     = depth_r;
    ptr_nxt       = ptr_r;
    pref_nxt      = pref_r;
    ccur_nxt      = ccur_r;
    best_nxt      = best_r;
    total_nxt     = total_r;
    tgt_nxt       = cfg_we ? cfg_wdata : tgt_r;
    s1_vld_nxt    = 1'b0;
    s1_org_nxt    = 1'b0;
    s1_j_nxt      = s1_j_r;
    out_valid_nxt = 1'b0;
    out_mp_nxt    = out_mp_r;
    out_tot_nxt   = out_tot_r;
    out_lst_nxt   = out_lst_r;
    out_ovf_nxt   = out_ovf_r;
    pos_we        = 1'b0;
    pos_waddr     = cnt_r[AW-1:0];
    pos_raddr     = i_r;
    cost_we       = 1'b0;
    cost_raddr    = lastidx;
    stk_we        = 1'b0;
    stk_waddr     = depth_r[AW-1:0];
    stk_wdata     = lastidx;
    stk_raddr     = ptr_r;

    // running minimum over candidates of the current stop
    if (((state_r == S_CR) || (state_r == S_CD)) && res.vld) begin
      if (res.org || (res.sum < best_r)) begin
        best_nxt = res.sum;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!full) begin
            pos_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt     = full ? cnt_r : cnt_r + CW'(1);
            i_nxt     = '0;
            state_nxt = S_CI;
          end
        end
      end

      // fetch the milepost of stop i
      S_CI: begin
        pos_raddr = i_r;
        k_nxt     = '0;
        state_nxt = S_CR;
      end

      // issue origin then every earlier stop
      S_CR: begin
        pos_raddr  = k_r - AW'(1);
        cost_raddr = k_r - AW'(1);
        s1_vld_nxt = 1'b1;
        s1_org_nxt = (k_r == '0);
        s1_j_nxt   = k_r - AW'(1);
        if (k_r == '0) begin
          pref_nxt = pos_q;
        end
        if (k_r == i_r) begin
          state_nxt = S_CD;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end

      // drain and store the cost of stop i
      S_CD: begin
        if (!s1_vld_r && !ev_busy) begin
          cost_we = 1'b1;
          if (i_r == lastidx) begin
            state_nxt = S_TI;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = S_CI;
          end
        end
      end

      // traceback starts at the final stop
      S_TI: begin
        pos_raddr  = lastidx;
        cost_raddr = lastidx;
        stk_we     = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = lastidx;
        depth_nxt  = CW'(1);
        state_nxt  = S_TC;
      end

      S_TC: begin
        pref_nxt  = pos_q;
        ccur_nxt  = cost_q;
        total_nxt = cost_q;
        if (lastidx == '0) begin
          ptr_nxt   = '0;
          state_nxt = S_EK;
        end else begin
          j_nxt     = lastidx - AW'(1);
          state_nxt = S_TR;
        end
      end

      // scan predecessors nearest first
      S_TR, S_TW: begin
        if (match) begin
          pref_nxt  = res.pos;
          ccur_nxt  = res.cost;
          stk_we    = 1'b1;
          stk_waddr = depth_r[AW-1:0];
          stk_wdata = s3_j_r;
          depth_nxt = depth_r + CW'(1);
          if (s3_j_r == '0) begin
            ptr_nxt   = depth_r[AW-1:0];
            state_nxt = S_EK;
          end else begin
            j_nxt     = s3_j_r - AW'(1);
            state_nxt = S_TR;
          end
        end else if (state_r == S_TR) begin
          pos_raddr  = j_r;
          cost_raddr = j_r;
          s1_vld_nxt = 1'b1;
          s1_j_nxt   = j_r;
          if (j_r == '0) begin
            state_nxt = S_TW;
          end else begin
            j_nxt = j_r - AW'(1);
          end
        end else if (!s1_vld_r && !ev_busy) begin
          // no stop matched: the leg comes from the origin
          ptr_nxt   = AW'(depth_r - CW'(1));
          state_nxt = S_EK;
        end
      end

      // play the stack out in forward order
      S_EK: begin
        stk_raddr = ptr_r;
        state_nxt = S_EP;
      end

      S_EP: begin
        pos_raddr = stk_q;
        state_nxt = S_EO;
      end

      S_EO: begin
        out_valid_nxt = 1'b1;
        out_mp_nxt    = pos_q;
        out_tot_nxt   = total_r;
        out_lst_nxt   = (ptr_r == '0);
        out_ovf_nxt   = ovf_r;
        if (ptr_r == '0) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r - AW'(1);
          state_nxt = S_EK;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      tgt_r       <= TARGET_RESET;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      tgt_r       <= tgt_nxt;
      s1_vld_r    <= s1_vld_nxt & ~match;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    j_r       <= j_nxt;
    depth_r   <= depth_nxt;
    ptr_r     <= ptr_nxt;
    pref_r    <= pref_nxt;
    ccur_r    <= ccur_nxt;
    best_r    <= best_nxt;
    total_r   <= total_nxt;
    s1_org_r  <= s1_org_nxt;
    s1_j_r    <= s1_j_nxt;
    s2_j_r    <= s1_j_r;
    s3_j_r    <= s2_j_r;
    out_mp_r  <= out_mp_nxt;
    out_tot_r <= out_tot_nxt;
    out_lst_r <= out_lst_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_stop_milepost = out_mp_r;
  assign out_total_penalty = out_tot_r;
  assign out_last_stop     = out_lst_r;
  assign out_overflow      = out_ovf_r;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum-penalty stop sequencer. Stop lists of
// varied shape and length are fed through the start/busy handshake with
// random gaps. A behavioral model of the leg-penalty program and its
// traceback predicts every output word, and each word leaving the block is
// compared in order against it. The target leg length is changed between
// lists, including its extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import mpss_pkg::*;

  localparam int MAX_STOPS     = 32;
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEM_GOAL     = 346;
  localparam int GAP_PCT       = 21;
  localparam longint COST_CAP  = longint'(COST_MAX);

  typedef enum int {
    TRIP_RISING,
    TRIP_SCATTER,
    TRIP_EXTREME,
    TRIP_CLUSTER
  } trip_kind_t;

  // one expected output word
  typedef struct {
    logic [POS_W-1:0]  milepost;
    logic [COST_W-1:0] penalty;
    logic              last_stop;
    logic              overflow;
  } stop_word_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [POS_W-1:0]  in_milepost = '0;
  logic              in_last     = 1'b0;
  logic              out_valid;
  logic [POS_W-1:0]  out_stop_milepost;
  logic [COST_W-1:0] out_total_penalty;
  logic              out_last_stop;
  logic              out_overflow;
  logic              cfg_we      = 1'b0;
  logic [POS_W-1:0]  cfg_wdata   = '0;

  // model state: target, loaded stops and their best costs
  logic [POS_W-1:0] leg_len = TARGET_RESET;
  int               stop_pos [MAX_STOPS];
  longint           best_cost [MAX_STOPS];
  int               stops_held     = 0;
  bit               stops_dropped  = 1'b0;
  stop_word_t       route_q [$];
  int               mismatch_count = 0;
  int               stored_count   = 0;
  bit               gaps_on        = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  min_penalty_stop_sequence #(
    .MAX_STOPS(MAX_STOPS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_milepost      (in_milepost),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stop_milepost(out_stop_milepost),
    .out_total_penalty(out_total_penalty),
    .out_last_stop    (out_last_stop),
    .out_overflow     (out_overflow),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  // squared deviation of a signed leg from the target
  function automatic longint leg_sq(input longint from_p, input longint to_p);
    longint dev;
    dev = longint'(leg_len) - (to_p - from_p);
    if (dev < 0) dev = -dev;
    return dev * dev;
  endfunction

  function automatic longint cap_add(input longint a, input longint b);
    longint s;
    s = a + b;
    return (s > COST_CAP) ? COST_CAP : s;
  endfunction

  // best cost per stop, traceback from the final stop, words in forward order
  function automatic void plan_route();
    int         path [MAX_STOPS];
    int         depth;
    int         cur;
    int         i;
    int         j;
    int         k;
    longint     cand;
    longint     total;
    bit         found;
    stop_word_t w;
    for (i = 0; i < stops_held; i++) begin
      best_cost[i] = leg_sq(longint'(0), longint'(stop_pos[i]));
      if (best_cost[i] > COST_CAP) best_cost[i] = COST_CAP;
      for (j = 0; j < i; j++) begin
        cand = cap_add(best_cost[j],
                       leg_sq(longint'(stop_pos[j]), longint'(stop_pos[i])));
        if (cand < best_cost[i]) best_cost[i] = cand;
      end
    end
    cur = stops_held - 1;
    path[0] = cur;
    depth = 1;
    found = 1'b1;
    while (found) begin
      found = 1'b0;
      j = cur - 1;
      while (j >= 0 && !found) begin
        cand = cap_add(best_cost[j],
                       leg_sq(longint'(stop_pos[j]), longint'(stop_pos[cur])));
        if (cand == best_cost[cur])
          found = 1'b1;
        else
          j--;
      end
      if (found) begin
        cur = j;
        path[depth] = cur;
        depth++;
      end
    end
    total = best_cost[stops_held - 1];
    for (k = depth - 1; k >= 0; k--) begin
      w.milepost  = POS_W'(stop_pos[path[k]]);
      w.penalty   = COST_W'(total);
      w.last_stop = (k == 0);
      w.overflow  = stops_dropped;
      route_q.insert(route_q.size(), w);
    end
    stops_held    = 0;
    stops_dropped = 1'b0;
  endfunction

  // offer one stop word, wait for it to be taken, then update the model
  task automatic send_stop(input logic [POS_W-1:0] mp, input logic last);
    if (gaps_on && $urandom_range(99) < GAP_PCT) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < GAP_PCT);
    end
    start       <= 1'b1;
    in_milepost <= mp;
    in_last     <= last;
    do @(posedge clk); while (busy);
    if (stops_held < MAX_STOPS) begin
      stop_pos[stops_held] = int'(mp);
      stops_held++;
      stored_count++;
    end else begin
      stops_dropped = 1'b1;
    end
    if (last) plan_route();
  endtask

  // one full list of n stops, the last one marked
  task automatic send_trip(input int n, input trip_kind_t kind);
    int pos;
    int k;
    pos = 0;
    for (k = 0; k < n; k++) begin
      case (kind)
        TRIP_RISING:  pos = (pos + $urandom_range(2 * int'(leg_len) + 100)) & 16'hFFFF;
        TRIP_SCATTER: pos = $urandom_range(65535);
        TRIP_EXTREME: begin
          case ($urandom_range(2))
            0:       pos = 0;
            1:       pos = 65535;
            default: pos = $urandom_range(65535);
          endcase
        end
        default:      pos = $urandom_range(1000);
      endcase
      send_stop(pos[POS_W-1:0], k == n - 1);
    end
  endtask

  // drop start, let every expected word arrive and the block fall quiet
  task automatic settle_block();
    start <= 1'b0;
    while (route_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_target(input logic [POS_W-1:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    leg_len = value;
  endtask

  // lists at the reset target: single stops, backward and equal legs
  task automatic test_reset_target();
    send_stop(16'd200, 1'b1);
    send_stop(16'd0, 1'b1);
    send_stop(16'hFFFF, 1'b1);
    send_stop(16'd100, 1'b0);
    send_stop(16'd200, 1'b0);
    send_stop(16'd400, 1'b1);
    send_stop(16'd500, 1'b0);
    send_stop(16'd300, 1'b0);
    send_stop(16'd100, 1'b1);
    send_stop(16'd1000, 1'b0);
    send_stop(16'd1000, 1'b0);
    send_stop(16'd1000, 1'b1);
  endtask

  // zero and full-scale target with full-scale legs both ways
  task automatic test_extreme_targets();
    set_target(16'd0);
    send_stop(16'd0, 1'b0);
    send_stop(16'd0, 1'b0);
    send_stop(16'hFFFF, 1'b1);
    set_target(16'hFFFF);
    send_stop(16'hFFFF, 1'b0);
    send_stop(16'd0, 1'b0);
    send_stop(16'hFFFF, 1'b1);
    send_stop(16'd0, 1'b0);
    send_stop(16'hFFFF, 1'b1);
  endtask

  // exactly full, final word dropped, extras dropped, then flag cleared
  task automatic test_overflow();
    set_target(16'd2000);
    send_trip(MAX_STOPS, TRIP_RISING);
    send_trip(MAX_STOPS + 1, TRIP_RISING);
    send_trip(MAX_STOPS + 5, TRIP_SCATTER);
    send_trip(2, TRIP_CLUSTER);
  endtask

  // random lists, mostly short, with target changes between lists
  task automatic test_random_trips();
    int         n;
    int         roll;
    int         base;
    trip_kind_t kind;
    base = stored_count;
    while (stored_count - base < ITEM_GOAL) begin
      gaps_on = !((stored_count - base) inside {[150:260]});
      if ($urandom_range(4) == 0) begin
        roll = $urandom_range(99);
        if (roll < 10)      set_target(16'd0);
        else if (roll < 20) set_target(16'hFFFF);
        else if (roll < 45) set_target(POS_W'($urandom_range(65535)));
        else                set_target(POS_W'($urandom_range(4000)));
      end
      roll = $urandom_range(99);
      if (roll < 80)      n = $urandom_range(10, 1);
      else if (roll < 92) n = $urandom_range(MAX_STOPS - 1, 11);
      else if (roll < 97) n = MAX_STOPS;
      else                n = $urandom_range(MAX_STOPS + 8, MAX_STOPS + 1);
      roll = $urandom_range(99);
      if (roll < 55)      kind = TRIP_RISING;
      else if (roll < 75) kind = TRIP_SCATTER;
      else if (roll < 85) kind = TRIP_EXTREME;
      else                kind = TRIP_CLUSTER;
      send_trip(n, kind);
    end
    gaps_on = 1'b1;
  endtask

  // compare each output word with the oldest expected stop
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (route_q.size() == 0) begin
        $error("unexpected out word: out_stop_milepost %0d", out_stop_milepost);
        mismatch_count++;
      end else begin
        if (out_stop_milepost !== route_q[0].milepost) begin
          $error("out_stop_milepost: expected %0d, got %0d",
                 route_q[0].milepost, out_stop_milepost);
          mismatch_count++;
        end
        if (out_total_penalty !== route_q[0].penalty) begin
          $error("out_total_penalty: expected %0d, got %0d",
                 route_q[0].penalty, out_total_penalty);
          mismatch_count++;
        end
        if (out_last_stop !== route_q[0].last_stop) begin
          $error("out_last_stop: expected %0b, got %0b",
                 route_q[0].last_stop, out_last_stop);
          mismatch_count++;
        end
        if (out_overflow !== route_q[0].overflow) begin
          $error("out_overflow: expected %0b, got %0b",
                 route_q[0].overflow, out_overflow);
          mismatch_count++;
        end
        route_q.pop_front();
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_target();
    test_extreme_targets();
    test_overflow();
    test_random_trips();
    settle_block();
    if (mismatch_count == 0 && route_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
